// ===== hw/rtl/llts_pkg.sv =====
// Shared types for the LCD line timing and STAT interrupt block.
// No dependencies; every other file in hw/rtl imports this package.
package llts_pkg;

  localparam int LINE_W = 8;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_DRAW   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0]        cycles;
    logic              lcd_enable;
    logic [LINE_W-1:0] compare_line;
    logic              lyc_int_enable;
    logic              hblank_int_enable;
    logic              vblank_int_enable;
    logic              oam_int_enable;
  } item_t;

  typedef struct packed {
    logic [LINE_W-1:0] line;
    mode_t             mode;
    logic              coincidence;
    logic              vblank_irq;
    logic              stat_irq;
    logic              hdma_request;
    logic              frame_swap;
    logic              oam_scan_start;
    logic              draw_start;
    logic              screen_clear;
  } result_t;

  // Handshake between the input register and the rest of the pipe.
  typedef struct packed {
    logic valid;
    logic take;
  } stage_ctl_t;

endpackage

// ===== hw/rtl/llts_in_reg.sv =====
// Input register stage of the LCD line timing block.
// Depends on llts_pkg.
module llts_in_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  llts_pkg::item_t    item_in,
  input  logic               take,
  output llts_pkg::stage_ctl_t ctl,
  output llts_pkg::item_t    item
);
  import llts_pkg::*;

  logic valid;

  // Accept whenever the register is empty or the held item leaves in the same cycle.
  assign in_ready  = !valid || take;
  assign ctl.valid = valid;
  assign ctl.take  = valid && take;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_in;
    end
  end

endmodule

// ===== hw/rtl/llts_core.sv =====
// Line timing state and status computation for one item per cycle while the result register can take it.
// Depends on llts_pkg.
module llts_core #(
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154,
  parameter int HBLANK_END    = 204,
  parameter int OAM_END       = 284
) (
  input  logic                 clk,
  input  logic                 rst,
  input  llts_pkg::stage_ctl_t ctl,
  input  llts_pkg::item_t      item,
  output llts_pkg::result_t    res
);
  import llts_pkg::*;

  localparam int CNT_W = $clog2(LINE_CYCLES + 256);

  logic [CNT_W-1:0]  line_cycle, line_cycle_next;
  logic [LINE_W-1:0] line_count, line_count_next;
  mode_t             cur_mode, cur_mode_next;
  logic              coincidence_flag, coincidence_flag_next;
  logic              stat_level, stat_level_next;
  logic              sprites_found, sprites_found_next;
  logic              line_drawn, line_drawn_next;
  logic              display_on;

  logic [CNT_W-1:0]  sum, cnt;
  logic [LINE_W:0]   ln;
  logic              advance, wrap, lvl;

  always_comb begin
    sum     = line_cycle + CNT_W'(item.cycles);
    advance = sum > CNT_W'(LINE_CYCLES);
    cnt     = advance ? sum - CNT_W'(LINE_CYCLES) : sum;
    ln      = {1'b0, line_count} + (LINE_W+1)'(1);
    wrap    = ln >= (LINE_W+1)'(TOTAL_LINES);

    line_cycle_next       = cnt;
    line_count_next       = line_count;
    sprites_found_next    = sprites_found;
    line_drawn_next       = line_drawn;
    cur_mode_next         = cur_mode;
    coincidence_flag_next = coincidence_flag;
    stat_level_next       = stat_level;
    lvl                   = 1'b0;

    res              = '0;
    res.mode         = cur_mode;
    res.coincidence  = coincidence_flag;

    if (!item.lcd_enable) begin
      // Hold status; counter and line go to zero.
      line_cycle_next  = '0;
      line_count_next  = '0;
      res.screen_clear = display_on;
    end else begin
      if (advance) begin
        sprites_found_next = 1'b0;
        line_drawn_next    = 1'b0;
        res.hdma_request   = ln < (LINE_W+1)'(VISIBLE_LINES);
        res.vblank_irq     = ln == (LINE_W+1)'(VISIBLE_LINES);
        res.frame_swap     = wrap;
        line_count_next    = wrap ? '0 : ln[LINE_W-1:0];
      end

      if (line_count_next >= LINE_W'(VISIBLE_LINES)) begin
        cur_mode_next = MODE_VBLANK;
      end else if (cnt <= CNT_W'(HBLANK_END)) begin
        cur_mode_next = MODE_HBLANK;
      end else if (cnt <= CNT_W'(OAM_END)) begin
        cur_mode_next      = MODE_OAM;
        res.oam_scan_start = !sprites_found_next;
        sprites_found_next = 1'b1;
      end else begin
        cur_mode_next   = MODE_DRAW;
        res.draw_start  = !line_drawn_next;
        line_drawn_next = 1'b1;
      end

      coincidence_flag_next = line_count_next == item.compare_line;

      lvl = (item.lyc_int_enable && coincidence_flag_next)
         || (cur_mode_next == MODE_HBLANK && item.hblank_int_enable)
         || (cur_mode_next == MODE_VBLANK && item.vblank_int_enable)
         || (cur_mode_next == MODE_OAM && item.oam_int_enable);
      res.stat_irq    = !stat_level && lvl;
      stat_level_next = lvl;

      res.mode        = cur_mode_next;
      res.coincidence = coincidence_flag_next;
    end

    res.line = line_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_cycle       <= '0;
      line_count       <= '0;
      cur_mode         <= MODE_HBLANK;
      coincidence_flag <= 1'b0;
      stat_level       <= 1'b0;
      sprites_found    <= 1'b0;
      line_drawn       <= 1'b0;
      display_on       <= 1'b0;
    end else if (ctl.take) begin
      line_cycle       <= line_cycle_next;
      line_count       <= line_count_next;
      cur_mode         <= cur_mode_next;
      coincidence_flag <= coincidence_flag_next;
      stat_level       <= stat_level_next;
      sprites_found    <= sprites_found_next;
      line_drawn       <= line_drawn_next;
      display_on       <= item.lcd_enable;
    end
  end

endmodule

// ===== hw/rtl/llts_out_reg.sv =====
// Result register stage of the LCD line timing block.
// Depends on llts_pkg.
module llts_out_reg (
  input  logic                 clk,
  input  logic                 rst,
  input  llts_pkg::stage_ctl_t ctl,
  input  llts_pkg::result_t    res_in,
  output logic                 take,
  output logic                 out_valid,
  input  logic                 out_ready,
  output llts_pkg::result_t    res
);
  import llts_pkg::*;

  // Load a new result whenever the register is empty or being drained.
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.take) begin
      res <= res_in;
    end
  end

endmodule

// ===== hw/rtl/lcd_line_timing_stat_irq.sv =====
// LCD line timing with STAT and vblank interrupt requests.
// Path: an accepted item is held in the input register, passes the core logic
// and is loaded into the result register once that register can take it.
// Throughput: one item per cycle while the output is not stalled, set by the single
// add/compare pass between the two registers.
// Reset (rst, synchronous): line counter, cycle counter, mode and all flags go
// to zero; no result is pending.
module lcd_line_timing_stat_irq #(
  parameter int LINE_CYCLES   = 456,
  parameter int VISIBLE_LINES = 144,
  parameter int TOTAL_LINES   = 154,
  parameter int HBLANK_END    = 204,
  parameter int OAM_END       = 284
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] cycles,
  input  logic       lcd_enable,
  input  logic [7:0] compare_line,
  input  logic       lyc_int_enable,
  input  logic       hblank_int_enable,
  input  logic       vblank_int_enable,
  input  logic       oam_int_enable,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] line,
  output logic [1:0] mode,
  output logic       coincidence,
  output logic       vblank_irq,
  output logic       stat_irq,
  output logic       hdma_request,
  output logic       frame_swap,
  output logic       oam_scan_start,
  output logic       draw_start,
  output logic       screen_clear
);
  import llts_pkg::*;

  item_t      item_in, item;
  stage_ctl_t ctl;
  result_t    res_next, res;
  logic       take;

  assign item_in.cycles            = cycles;
  assign item_in.lcd_enable        = lcd_enable;
  assign item_in.compare_line      = compare_line;
  assign item_in.lyc_int_enable    = lyc_int_enable;
  assign item_in.hblank_int_enable = hblank_int_enable;
  assign item_in.vblank_int_enable = vblank_int_enable;
  assign item_in.oam_int_enable    = oam_int_enable;

  llts_in_reg u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .item_in  (item_in),
    .take     (take),
    .ctl      (ctl),
    .item     (item)
  );

  llts_core #(
    .LINE_CYCLES   (LINE_CYCLES),
    .VISIBLE_LINES (VISIBLE_LINES),
    .TOTAL_LINES   (TOTAL_LINES),
    .HBLANK_END    (HBLANK_END),
    .OAM_END       (OAM_END)
  ) u_core (
    .clk  (clk),
    .rst  (rst),
    .ctl  (ctl),
    .item (item),
    .res  (res_next)
  );

  llts_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .res_in    (res_next),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res)
  );

  assign line           = res.line;
  assign mode           = res.mode;
  assign coincidence    = res.coincidence;
  assign vblank_irq     = res.vblank_irq;
  assign stat_irq       = res.stat_irq;
  assign hdma_request   = res.hdma_request;
  assign frame_swap     = res.frame_swap;
  assign oam_scan_start = res.oam_scan_start;
  assign draw_start     = res.draw_start;
  assign screen_clear   = res.screen_clear;

endmodule

// ===== hw/rtl/llts_checker.sv =====
// Port-level checks for lcd_line_timing_stat_irq, bound to the top level.
// Depends on llts_pkg and lcd_line_timing_stat_irq.
module llts_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] line,
  input logic [1:0] mode,
  input logic       vblank_irq,
  input logic       stat_irq,
  input logic       hdma_request,
  input logic       frame_swap,
  input logic       oam_scan_start,
  input logic       draw_start,
  input logic       screen_clear
);
  import llts_pkg::*;

  // Stalled result stays put.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(line) && $stable(mode))
    else $error("result changed while stalled");

  a_swap_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_swap |-> line == '0 && !hdma_request)
    else $error("frame swap without line wrap");

  a_vblank_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && vblank_irq |-> mode == MODE_VBLANK && !hdma_request)
    else $error("vblank request outside vblank mode");

  a_start_mode: assert property (@(posedge clk) disable iff (rst)
    out_valid && (oam_scan_start || draw_start) |->
      (oam_scan_start && mode == MODE_OAM && !draw_start)
      || (draw_start && mode == MODE_DRAW && !oam_scan_start))
    else $error("scan or draw start in the wrong mode");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && screen_clear |-> line == '0 && !stat_irq && !vblank_irq
      && !hdma_request && !frame_swap && !oam_scan_start && !draw_start)
    else $error("screen clear with timing pulses");

endmodule

bind lcd_line_timing_stat_irq llts_checker u_llts_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .line           (line),
  .mode           (mode),
  .vblank_irq     (vblank_irq),
  .stat_irq       (stat_irq),
  .hdma_request   (hdma_request),
  .frame_swap     (frame_swap),
  .oam_scan_start (oam_scan_start),
  .draw_start     (draw_start),
  .screen_clear   (screen_clear)
);
